// ===== rtl/scoo_pkg.sv =====
package scoo_pkg;

  localparam int MAX_LEN_DEFAULT = 64;

  localparam int LEN_W     = 7;
  localparam int VEC_IDX_W = 6;
  localparam int MAT_IDX_W = 7;
  localparam int VALUE_W   = 32;
  localparam int ACC_W     = 64;
  localparam int OUT_ROW_W = 6;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [LEN_W-1:0] VECTOR_LENGTH_RESET = 7'd64;

  // register index, taken from paddr[2]
  localparam logic REG_VECTOR_LENGTH = 1'b0;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENTRY  = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]                action;
    logic [VEC_IDX_W-1:0]      vec_index;
    logic [MAT_IDX_W-1:0]      row_index;
    logic [MAT_IDX_W-1:0]      col_index;
    logic signed [VALUE_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [OUT_ROW_W-1:0]      out_row;
    logic signed [VALUE_W-1:0] row_sum;
    logic                      dim_error;
    logic                      last_row;
  } out_item_t;

endpackage

// ===== rtl/sparse_coo_matrix_vector_multiply.sv =====
// sparse matrix (coordinate triplets) times dense vector, signed q16.16.
// a load item writes one vector element. a matrix entry whose row and
// column lie inside the length reads x and the row sum, does one 32x32
// multiply, then a saturating 64-bit add and write back through the
// accumulator memory; an entry outside the length adds nothing.
// a finish item checks the dimensions, then reads and emits one result
// per row, holding while the output side stalls; a dimension error
// gives one result instead. row sums are cleared by per-row valid bits,
// so no clearing pass is needed after reset or after a finish that
// emits its rows; a dimension error leaves the valid bits set. the
// input is not ready while an item is at work; a result may still wait
// in the output register while the next load or entry is taken.
// vector_length is written over the apb port at byte address 0 and is
// clamped to 1..MAX_LEN when used.
module sparse_coo_matrix_vector_multiply #(
  parameter int MAX_LEN = scoo_pkg::MAX_LEN_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input item channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  scoo_pkg::in_item_t                    in_data,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output scoo_pkg::out_item_t                   out_data,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [scoo_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [scoo_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [scoo_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  import scoo_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);

  // sequencer codes
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MUL     = 3'd1;
  localparam logic [2:0] S_ACC     = 3'd2;
  localparam logic [2:0] S_FIN     = 3'd3;
  localparam logic [2:0] S_EMIT_RD = 3'd4;
  localparam logic [2:0] S_EMIT_LD = 3'd5;

  logic [2:0]              state;
  logic [LEN_W-1:0]        vector_length;
  logic [LEN_W-1:0]        len_eff;
  logic [MAT_IDX_W-1:0]    max_col;
  logic [MAX_LEN-1:0]      acc_valid;
  logic [AW-1:0]           cnt;
  logic [AW-1:0]           row_addr;
  logic signed [VALUE_W-1:0] op_value;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] acc_hold;

  logic                    in_xfer;
  logic                    out_free;
  logic                    out_load;
  logic                    entry_in_range;
  logic                    dim_bad;
  logic                    cnt_last;

  logic                    x_we;
  logic [VALUE_W-1:0]      x_rdata;
  logic                    acc_we;
  logic [AW-1:0]           acc_raddr;
  logic [ACC_W-1:0]        acc_rdata;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] prod_q;
  logic signed [ACC_W-1:0] emit_acc;
  logic signed [VALUE_W-1:0] emit_sat;

  // apb: always ready, single register at index 0
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_VECTOR_LENGTH) begin
      prdata = APB_DATA_W'(vector_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= VECTOR_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_VECTOR_LENGTH) begin
      vector_length <= pwdata[LEN_W-1:0];
    end
  end

  // length clamped to 1..MAX_LEN
  always_comb begin
    if (vector_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (vector_length > MAX_LEN_L) begin
      len_eff = MAX_LEN_L;
    end else begin
      len_eff = vector_length;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign entry_in_range = (in_data.row_index < len_eff) && (in_data.col_index < len_eff);
  assign dim_bad  = ({1'b0, max_col} + 8'd1) != {1'b0, len_eff};
  assign cnt_last = (LEN_W'(cnt) + LEN_W'(1)) == len_eff;

  // a new result enters the output register this cycle
  assign out_load = out_free && ((state == S_FIN && dim_bad) || state == S_EMIT_LD);

  // vector store: elements past MAX_LEN could never be read
  assign x_we = in_xfer && in_data.action == ACT_LOAD &&
                {1'b0, in_data.vec_index} < MAX_LEN_L;

  scoo_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_LEN),
    .ADDR_W(AW)
  ) u_x_ram (
    .clk  (clk),
    .we   (x_we),
    .waddr(in_data.vec_index[AW-1:0]),
    .wdata(in_data.operand_value),
    .raddr(in_data.col_index[AW-1:0]),
    .rdata(x_rdata)
  );

  // accumulator memory, read by the entry path or the emit sweep
  assign acc_raddr = (state == S_EMIT_RD || state == S_EMIT_LD) ? cnt
                                                                : in_data.row_index[AW-1:0];
  assign acc_we = (state == S_ACC);

  scoo_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_LEN),
    .ADDR_W(AW)
  ) u_acc_ram (
    .clk  (clk),
    .we   (acc_we),
    .waddr(row_addr),
    .wdata(acc_next),
    .raddr(acc_raddr),
    .rdata(acc_rdata)
  );

  // q32.32 product to q16.16, floor, then saturating add
  always_comb begin
    prod_q  = prod >>> 16;
    acc_sum = acc_hold + prod_q;
    acc_next = acc_sum;
    if (acc_hold[ACC_W-1] == prod_q[ACC_W-1] && acc_sum[ACC_W-1] != acc_hold[ACC_W-1]) begin
      acc_next = acc_hold[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  // emitted sum, saturated to 32 bits; unwritten rows read as zero
  always_comb begin
    emit_acc = acc_valid[cnt] ? $signed(acc_rdata) : '0;
    if (emit_acc[ACC_W-1:VALUE_W-1] == '0 || emit_acc[ACC_W-1:VALUE_W-1] == '1) begin
      emit_sat = emit_acc[VALUE_W-1:0];
    end else if (emit_acc[ACC_W-1]) begin
      emit_sat = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      emit_sat = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_value <= in_data.operand_value;
      row_addr <= in_data.row_index[AW-1:0];
    end
    if (state == S_MUL) begin
      prod     <= op_value * $signed(x_rdata);
      acc_hold <= acc_valid[row_addr] ? $signed(acc_rdata) : '0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      max_col   <= '0;
      acc_valid <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_data.action == ACT_ENTRY) begin
              if (in_data.col_index > max_col) begin
                max_col <= in_data.col_index;
              end
              if (entry_in_range) begin
                state <= S_MUL;
              end
            end else if (in_data.action == ACT_FINISH) begin
              state <= S_FIN;
            end
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          acc_valid[row_addr] <= 1'b1;
          state <= S_IDLE;
        end
        S_FIN: begin
          if (dim_bad) begin
            if (out_free) begin
              out_data.out_row   <= '0;
              out_data.row_sum   <= '0;
              out_data.dim_error <= 1'b1;
              out_data.last_row  <= 1'b1;
              state              <= S_IDLE;
            end
          end else begin
            cnt   <= '0;
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          // read address holds on cnt while the output side stalls
          if (out_free) begin
            out_data.out_row   <= OUT_ROW_W'(cnt);
            out_data.row_sum   <= emit_sat;
            out_data.dim_error <= 1'b0;
            out_data.last_row  <= cnt_last;
            acc_valid[cnt]     <= 1'b0;
            if (cnt_last) begin
              state <= S_IDLE;
            end else begin
              cnt   <= cnt + AW'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/scoo_ram.sv =====
module scoo_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
